[hw/rtl/capped_edit_distance_top_assert.svh]
// ----------------------------------------------------------------------------
// Capped edit distance assertion macros
// Concurrent check macros shared by the capped edit distance RTL.
// ----------------------------------------------------------------------------
`ifndef CAPPED_EDIT_DISTANCE_TOP_ASSERT_SVH
`define CAPPED_EDIT_DISTANCE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons holds.
`define CED_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("capped edit distance check failed");

// Next-cycle implication: when ante holds, cons holds in the following cycle.
`define CED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("capped edit distance check failed");

`else

`define CED_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define CED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/ced_pkg.sv]
// ----------------------------------------------------------------------------
// Capped edit distance package
// Sizes, request codes, inter-module structs and small cell helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ced_pkg;

    localparam int unsigned MAX_LEN = 32;
    localparam int unsigned CAP_MAX = 3;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned CAP_W  = 2;
    localparam int unsigned CELL_W = 3;
    localparam int unsigned LEN_W  = $clog2(MAX_LEN + 1);
    localparam int unsigned REF_AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned ROWS   = MAX_LEN + 1;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_EMPTY = 2'd2
    } req_type_t;

    // Row sweep command from the top level to the row engine
    typedef struct packed {
        logic              go;
        logic              first;
        logic [CHAR_W-1:0] ch;
        logic [CELL_W-1:0] sat;
        logic [CELL_W-1:0] qpos;
        logic [LEN_W-1:0]  len;
    } row_cmd_t;

    // Sweep completion from the row engine
    typedef struct packed {
        logic              valid;
        logic [CELL_W-1:0] score;
    } row_done_t;

    function automatic logic [CAP_W-1:0] take_cap(input logic [CAP_W-1:0] c);
        if (32'(c) > CAP_MAX)
            return CAP_W'(CAP_MAX);
        return c;
    endfunction

    function automatic logic [CELL_W-1:0] cell_min(input logic [CELL_W-1:0] a,
                                                   input logic [CELL_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // Initial row value of column idx: min(idx, sat)
    function automatic logic [CELL_W-1:0] cell_init(input logic [LEN_W-1:0]  idx,
                                                    input logic [CELL_W-1:0] sat);
        if (idx < LEN_W'(sat))
            return idx[CELL_W-1:0];
        return sat;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ced_ref_store.sv]
// ----------------------------------------------------------------------------
// Capped edit distance reference store
// Reference character memory and length counter; registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ced_ref_store
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire logic                         wr_first,
    input  wire logic [ced_pkg::CHAR_W-1:0]   wr_ch,
    input  wire logic [ced_pkg::REF_AW-1:0]   rd_addr,
    output logic      [ced_pkg::CHAR_W-1:0]   rd_data,
    output logic      [ced_pkg::LEN_W-1:0]    ref_len
);

    logic [ced_pkg::CHAR_W-1:0] ref_mem [0:ced_pkg::MAX_LEN-1];
    logic [ced_pkg::CHAR_W-1:0] rd_data_reg;
    logic [ced_pkg::LEN_W-1:0]  len_reg;
    logic [ced_pkg::LEN_W-1:0]  len_next;
    logic [ced_pkg::LEN_W-1:0]  wr_slot;
    logic                       wr_do;

    always_comb
    begin
        wr_slot  = wr_first ? '0 : len_reg;
        wr_do    = wr_en && (32'(wr_slot) < ced_pkg::MAX_LEN);
        len_next = len_reg;
        if (wr_do)
            len_next = wr_slot + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= '0;
        else
            len_reg <= len_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_do)
            ref_mem[wr_slot[ced_pkg::REF_AW-1:0]] <= wr_ch;
        rd_data_reg <= ref_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign ref_len = len_reg;

endmodule

`default_nettype wire

[hw/rtl/ced_row_engine.sv]
// ----------------------------------------------------------------------------
// Capped edit distance row engine
// Sweeps the row memory one cell a cycle: read, update, write back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "capped_edit_distance_top_assert.svh"

module ced_row_engine
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ced_pkg::row_cmd_t            cmd,
    output logic      [ced_pkg::REF_AW-1:0]   ref_addr,
    input  wire logic [ced_pkg::CHAR_W-1:0]   ref_data,
    output ced_pkg::row_done_t                done
);

    logic [ced_pkg::CELL_W-1:0] row_mem [0:ced_pkg::ROWS-1];

    // sweep control
    logic                       rd_en_reg;
    logic [ced_pkg::LEN_W-1:0]  rd_idx_reg;
    logic                       wb_valid_reg;
    logic [ced_pkg::LEN_W-1:0]  wb_idx_reg;
    logic                       fin_reg;

    // latched request and datapath
    logic                       first_reg;
    logic [ced_pkg::CHAR_W-1:0] ch_reg;
    logic [ced_pkg::CELL_W-1:0] sat_reg;
    logic [ced_pkg::CELL_W-1:0] qpos_reg;
    logic [ced_pkg::LEN_W-1:0]  len_reg;
    logic [ced_pkg::LEN_W-1:0]  end_reg;
    logic [ced_pkg::CELL_W-1:0] row_q_reg;
    logic [ced_pkg::CELL_W-1:0] left_reg;
    logic [ced_pkg::CELL_W-1:0] diag_reg;
    logic [ced_pkg::CELL_W-1:0] res_reg;

    logic [ced_pkg::CELL_W-1:0] up;
    logic [ced_pkg::CELL_W-1:0] cost;
    logic [ced_pkg::CELL_W-1:0] best;
    logic [ced_pkg::CELL_W-1:0] cell_next;
    logic [ced_pkg::LEN_W-1:0]  ref_idx;

    always_comb
    begin
        up   = first_reg ? ced_pkg::cell_init(wb_idx_reg, sat_reg) : row_q_reg;
        cost = (ref_data == ch_reg) ? '0 : ced_pkg::CELL_W'(1);
        best = ced_pkg::cell_min(up + 1'b1, left_reg + 1'b1);
        best = ced_pkg::cell_min(best, diag_reg + cost);
        best = ced_pkg::cell_min(best, sat_reg);
        priority if (wb_idx_reg == '0)
            cell_next = qpos_reg;
        else if (wb_idx_reg > len_reg)
            cell_next = up;
        else
            cell_next = best;
    end

    // reference char for column j sits at j-1; column zero ignores it
    assign ref_idx  = rd_idx_reg - 1'b1;
    assign ref_addr = ref_idx[ced_pkg::REF_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_en_reg    <= 1'b0;
            rd_idx_reg   <= '0;
            wb_valid_reg <= 1'b0;
            wb_idx_reg   <= '0;
            fin_reg      <= 1'b0;
        end
        else if (cmd.go)
        begin
            rd_en_reg    <= 1'b1;
            rd_idx_reg   <= '0;
            wb_valid_reg <= 1'b0;
            fin_reg      <= 1'b0;
        end
        else
        begin
            wb_valid_reg <= rd_en_reg;
            wb_idx_reg   <= rd_idx_reg;
            if (rd_en_reg)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
                rd_en_reg  <= (rd_idx_reg != end_reg);
            end
            fin_reg <= wb_valid_reg && (wb_idx_reg == end_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.go)
        begin
            first_reg <= cmd.first;
            ch_reg    <= cmd.ch;
            sat_reg   <= cmd.sat;
            qpos_reg  <= cmd.qpos;
            len_reg   <= cmd.len;
            // a fresh query initialises every column, not only those in use
            end_reg   <= cmd.first ? ced_pkg::LEN_W'(ced_pkg::MAX_LEN) : cmd.len;
        end
        if (rd_en_reg)
            row_q_reg <= row_mem[rd_idx_reg];
        if (wb_valid_reg)
        begin
            row_mem[wb_idx_reg] <= cell_next;
            left_reg            <= cell_next;
            diag_reg            <= up;
            if (wb_idx_reg == len_reg)
                res_reg <= cell_next;
        end
    end

    assign done.valid = fin_reg;
    assign done.score = res_reg;

    `CED_ASSERT_NOW(a_no_overlap, clk, rst_n, wb_valid_reg && rd_en_reg, wb_idx_reg != rd_idx_reg)
    `CED_ASSERT_NOW(a_idx_range, clk, rst_n, rd_en_reg && !cmd.go, rd_idx_reg <= end_reg)
    `CED_ASSERT_NEXT(a_fin_single, clk, rst_n, fin_reg, !fin_reg)

endmodule

`default_nettype wire

[hw/rtl/capped_edit_distance_top.sv]
// ----------------------------------------------------------------------------
// Capped edit distance top level
// Bounded Levenshtein distance of a stored reference against a streamed query.
//
// Requests enter on start while busy is low; req_type selects a reference
// load, a query character or an empty query. Loads and empty queries leave
// busy low. A query character holds busy high from acceptance while the row
// engine sweeps the row memory one cell per cycle. The first character of
// a query sweeps and initialises every column; later ones sweep up to len.
// A result appears on distance/within_cap with done high for exactly one
// cycle: the cycle after an empty query, or at the end of the sweep of a
// character marked last. The receiver cannot stall; results are never held.
// Reset clears the reference length, cap and query position; the memories
// are not cleared, and a query must open with its first character.
// ----------------------------------------------------------------------------
`default_nettype none

`include "capped_edit_distance_top_assert.svh"

module capped_edit_distance_top
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   req_type,
    input  wire logic [ced_pkg::CHAR_W-1:0]   ch,
    input  wire logic                         first,
    input  wire logic                         last,
    input  wire logic [ced_pkg::CAP_W-1:0]    cap,
    output logic                              done,
    output logic      [ced_pkg::CELL_W-1:0]   distance,
    output logic                              within_cap
);

    logic                        busy_reg;
    logic                        busy_next;
    logic                        last_reg;
    logic                        last_next;
    logic [ced_pkg::CAP_W-1:0]   cap_latched_reg;
    logic [ced_pkg::CAP_W-1:0]   cap_latched_next;
    logic [ced_pkg::CELL_W-1:0]  qpos_reg;
    logic [ced_pkg::CELL_W-1:0]  qpos_next;
    logic                        done_reg;
    logic                        done_next;
    logic [ced_pkg::CELL_W-1:0]  distance_reg;
    logic [ced_pkg::CELL_W-1:0]  distance_next;
    logic                        within_reg;
    logic                        within_next;

    logic                        accept;
    logic [ced_pkg::CAP_W-1:0]   cap_taken;
    logic [ced_pkg::CAP_W-1:0]   cap_sel;
    logic [ced_pkg::CELL_W-1:0]  sat_sel;
    logic [ced_pkg::CELL_W-1:0]  qpos_base;
    logic [ced_pkg::CELL_W-1:0]  cap_ext;
    logic [ced_pkg::LEN_W-1:0]   ref_len;
    logic [ced_pkg::REF_AW-1:0]  ref_addr;
    logic [ced_pkg::CHAR_W-1:0]  ref_data;
    logic                        load_en;
    ced_pkg::row_cmd_t           row_cmd;
    ced_pkg::row_done_t          row_done;

    assign accept    = start && !busy_reg;
    assign cap_taken = ced_pkg::take_cap(cap);
    assign cap_ext   = ced_pkg::CELL_W'(cap_latched_reg);

    always_comb
    begin
        busy_next        = busy_reg;
        last_next        = last_reg;
        cap_latched_next = cap_latched_reg;
        qpos_next        = qpos_reg;
        done_next        = 1'b0;
        distance_next    = distance_reg;
        within_next      = within_reg;
        load_en          = 1'b0;

        // a first character or an empty query takes the new cap
        cap_sel   = first ? cap_taken : cap_latched_reg;
        sat_sel   = ced_pkg::CELL_W'(cap_sel) + 1'b1;
        qpos_base = first ? '0 : qpos_reg;

        row_cmd.go    = 1'b0;
        row_cmd.first = first;
        row_cmd.ch    = ch;
        row_cmd.sat   = sat_sel;
        row_cmd.qpos  = ced_pkg::cell_min(qpos_base + 1'b1, sat_sel);
        row_cmd.len   = ref_len;

        if (accept)
        begin
            unique case (ced_pkg::req_type_t'(req_type))
                ced_pkg::REQ_LOAD:
                begin
                    load_en = 1'b1;
                end
                ced_pkg::REQ_QUERY:
                begin
                    row_cmd.go       = 1'b1;
                    busy_next        = 1'b1;
                    last_next        = last;
                    cap_latched_next = cap_sel;
                    qpos_next        = row_cmd.qpos;
                end
                ced_pkg::REQ_EMPTY:
                begin
                    cap_latched_next = cap_taken;
                    qpos_next        = '0;
                    done_next        = 1'b1;
                    sat_sel          = ced_pkg::CELL_W'(cap_taken) + 1'b1;
                    if (ref_len < ced_pkg::LEN_W'(sat_sel))
                        distance_next = ref_len[ced_pkg::CELL_W-1:0];
                    else
                        distance_next = sat_sel;
                    within_next = (distance_next <= ced_pkg::CELL_W'(cap_taken));
                end
                default:
                begin
                    // unused request code: drop it
                end
            endcase
        end

        // end of sweep: release the request and report if it closed the query
        if (row_done.valid)
        begin
            busy_next = 1'b0;
            if (last_reg)
            begin
                done_next     = 1'b1;
                distance_next = row_done.score;
                within_next   = (row_done.score <= cap_ext);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            last_reg        <= 1'b0;
            cap_latched_reg <= '0;
            qpos_reg        <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            busy_reg        <= busy_next;
            last_reg        <= last_next;
            cap_latched_reg <= cap_latched_next;
            qpos_reg        <= qpos_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        distance_reg <= distance_next;
        within_reg   <= within_next;
    end

    ced_ref_store u_ref_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (load_en),
        .wr_first (first),
        .wr_ch    (ch),
        .rd_addr  (ref_addr),
        .rd_data  (ref_data),
        .ref_len  (ref_len)
    );

    ced_row_engine u_row_engine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (row_cmd),
        .ref_addr (ref_addr),
        .ref_data (ref_data),
        .done     (row_done)
    );

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign distance   = distance_reg;
    assign within_cap = within_reg;

    `CED_ASSERT_NEXT(a_query_busy, clk, rst_n, accept && req_type == ced_pkg::REQ_QUERY, busy_reg)
    `CED_ASSERT_NOW(a_fin_in_busy, clk, rst_n, row_done.valid, busy_reg)
    `CED_ASSERT_NEXT(a_fin_release, clk, rst_n, row_done.valid, !busy_reg)
    `CED_ASSERT_NOW(a_within_flag, clk, rst_n, done_reg, within_reg == (distance_reg <= cap_ext))

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capped edit distance testbench
// Streams reference loads, query characters and empty queries into the block,
// predicts every capped distance from a bit-true dynamic programming row kept
// here, and compares each done strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    import ced_pkg::*;

    // Request code that the block must ignore
    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int unsigned ITEMS_TARGET = 550;
    localparam int unsigned MAX_REPORTS  = 10;
    // Longest sweep is that of a first character; the drain adds margin
    localparam int unsigned DRAIN_CYCLES = 48;

    typedef struct packed {
        logic [CELL_W-1:0] distance;
        logic              within_cap;
    } score_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        req_type;
    logic [CHAR_W-1:0] ch;
    logic              first;
    logic              last;
    logic [CAP_W-1:0]  cap;
    logic              done;
    logic [CELL_W-1:0] distance;
    logic              within_cap;

    // Scores predicted at request acceptance, oldest first
    score_t pending_scores[$];

    // Predictor state: stored reference, DP row, query progress and cap
    logic [CHAR_W-1:0] ref_chars [MAX_LEN];
    int unsigned       ref_len;
    logic [CELL_W-1:0] dp_row [MAX_LEN+1];
    int unsigned       query_pos;
    int unsigned       cap_held;
    // Set once a first query character has initialised the row
    bit                row_ready;

    int unsigned items_sent;
    int unsigned mismatch_count;
    // While set, the sender issues requests back to back
    bit          burst_mode;

    capped_edit_distance_top i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .ch         (ch),
        .first      (first),
        .last       (last),
        .cap        (cap),
        .done       (done),
        .distance   (distance),
        .within_cap (within_cap)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction: apply one accepted request to the local row and queue
    // any score that it produces.
    // ------------------------------------------------------------------
    function automatic int unsigned smaller(input int unsigned a, input int unsigned b);
        return (a < b) ? a : b;
    endfunction

    // Append a predicted score behind those still outstanding
    task automatic queue_score(input score_t s);
        pending_scores.insert(pending_scores.size(), s);
    endtask

    task automatic predict_request(input logic [1:0] kind, input logic [CHAR_W-1:0] c,
                                   input logic is_first, input logic is_last,
                                   input logic [CAP_W-1:0] cp);
        int unsigned sat;
        int unsigned diag;
        int unsigned up;
        int unsigned cost;
        int unsigned v;
        int unsigned d;
        score_t      s;
        case (kind)
            REQ_LOAD:
            begin
                if (is_first)
                    ref_len = 0;
                // Drop characters beyond the reference store
                if (ref_len < MAX_LEN)
                begin
                    ref_chars[ref_len] = c;
                    ref_len++;
                end
            end
            REQ_EMPTY:
            begin
                cap_held  = smaller(cp, CAP_MAX);
                query_pos = 0;
                sat       = cap_held + 1;
                d         = smaller(ref_len, sat);
                s.distance   = CELL_W'(d);
                s.within_cap = (d <= cap_held);
                queue_score(s);
            end
            REQ_QUERY:
            begin
                if (is_first)
                begin
                    cap_held  = smaller(cp, CAP_MAX);
                    query_pos = 0;
                    sat       = cap_held + 1;
                    for (int j = 0; j <= MAX_LEN; j++)
                        dp_row[j] = CELL_W'(smaller(j, sat));
                    row_ready = 1'b1;
                end
                sat       = cap_held + 1;
                query_pos = smaller(query_pos + 1, sat);
                diag      = dp_row[0];
                dp_row[0] = CELL_W'(query_pos);
                for (int j = 1; j <= ref_len; j++)
                begin
                    up   = dp_row[j];
                    cost = (ref_chars[j-1] == c) ? 0 : 1;
                    v    = smaller(up + 1, dp_row[j-1] + 1);
                    v    = smaller(v, diag + cost);
                    diag = up;
                    dp_row[j] = CELL_W'(smaller(v, sat));
                end
                if (is_last)
                begin
                    d = smaller(dp_row[ref_len], sat);
                    s.distance   = CELL_W'(d);
                    s.within_cap = (d <= cap_held);
                    queue_score(s);
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request driver: present at the falling edge, hold until accepted,
    // then optionally idle for a random number of cycles.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [1:0] kind, input logic [CHAR_W-1:0] c,
                                input logic is_first, input logic is_last,
                                input logic [CAP_W-1:0] cp);
        int unsigned gap;
        @(negedge clk);
        req_type <= kind;
        ch       <= c;
        first    <= is_first;
        last     <= is_last;
        cap      <= cp;
        start    <= 1'b1;
        // Accepted at the first rising edge that sees busy low
        forever
        begin
            @(posedge clk);
            if (busy === 1'b0)
                break;
        end
        predict_request(kind, c, is_first, is_last, cp);
        if (kind != REQ_UNUSED)
            items_sent++;
        gap = burst_mode ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drop start and hold off until every predicted score has arrived
    task automatic settle_queries();
        @(negedge clk);
        start <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge clk);
    endtask

    // Mostly a small alphabet so that matches are common, else any byte
    function automatic logic [CHAR_W-1:0] pick_char();
        if ($urandom_range(0, 4) != 0)
            return CHAR_W'(8'h41 + $urandom_range(0, 2));
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what, input score_t want, input bit have_want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            if (have_want)
                $display("%0t: %s: expected distance %0d within_cap %0d, got %0d %0d",
                         $realtime, what, want.distance, want.within_cap,
                         distance, within_cap);
            else
                $display("%0t: %s: got distance %0d within_cap %0d", $realtime, what,
                         distance, within_cap);
        end
    endtask

    // ------------------------------------------------------------------
    // Score checker: every done strobe must match the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_scores
        score_t want;
        if (rst_n === 1'b1 && done !== 1'b0)
        begin
            if (pending_scores.size() == 0)
            begin
                want = '0;
                report_mismatch("unexpected score", want, 1'b0);
            end
            else
            begin
                want = pending_scores.pop_front();
                if (done !== 1'b1 || distance !== want.distance ||
                    within_cap !== want.within_cap)
                    report_mismatch("score mismatch", want, 1'b1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty reference after reset, ignored request codes, bare query
    task automatic test_empty_reference();
        send_request(REQ_EMPTY, 8'h00, 1'b0, 1'b0, 2'd0);
        send_request(REQ_UNUSED, 8'hFF, 1'b1, 1'b1, 2'd3);
        send_request(REQ_QUERY, 8'h00, 1'b1, 1'b1, 2'd3);
        send_request(REQ_UNUSED, 8'h00, 1'b0, 1'b0, 2'd0);
        send_request(REQ_EMPTY, 8'hFF, 1'b1, 1'b1, 2'd3);
    endtask

    // Short reference with extreme bytes: match, cap zero, both empty caps,
    // a deletion, and a load that grows the reference in the middle of a query
    task automatic test_short_strings();
        send_request(REQ_LOAD, 8'h00, 1'b1, 1'b0, 2'd0);
        send_request(REQ_LOAD, 8'hFF, 1'b0, 1'b1, 2'd3);
        send_request(REQ_QUERY, 8'h00, 1'b1, 1'b0, 2'd3);
        send_request(REQ_QUERY, 8'hFF, 1'b0, 1'b1, 2'd0);
        send_request(REQ_QUERY, 8'h55, 1'b1, 1'b1, 2'd0);
        send_request(REQ_EMPTY, 8'hAA, 1'b0, 1'b0, 2'd2);
        send_request(REQ_EMPTY, 8'h00, 1'b0, 1'b0, 2'd1);
        send_request(REQ_QUERY, 8'hFF, 1'b1, 1'b1, 2'd3);
        // Reference grows while the query is open
        send_request(REQ_QUERY, 8'h00, 1'b1, 1'b0, 2'd2);
        send_request(REQ_LOAD, 8'h80, 1'b0, 1'b0, 2'd1);
        send_request(REQ_QUERY, 8'hFF, 1'b0, 1'b1, 2'd1);
        // Query that resumes after an empty query resets its position
        send_request(REQ_EMPTY, 8'h01, 1'b1, 1'b0, 2'd3);
        send_request(REQ_QUERY, 8'h80, 1'b0, 1'b1, 2'd3);
        settle_queries();
    endtask

    // Overfill the reference store, then match it in full
    task automatic test_long_reference();
        for (int k = 0; k < MAX_LEN + 2; k++)
            send_request(REQ_LOAD, CHAR_W'($urandom_range(0, 255)), k == 0,
                         1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
        send_request(REQ_EMPTY, 8'h00, 1'b0, 1'b0, 2'd3);
        for (int k = 0; k < MAX_LEN; k++)
            send_request(REQ_QUERY, ref_chars[k], k == 0, k == MAX_LEN - 1, 2'd3);
        settle_queries();
    endtask

    // Mostly well-formed references and queries with mutated content,
    // mixed with empty queries and loose single requests
    task automatic test_random_sequences();
        int unsigned pick;
        int unsigned n;
        int unsigned qlen;
        int          span;
        logic [CAP_W-1:0]  cp;
        logic [CHAR_W-1:0] c;
        logic [1:0]        kind;
        logic              f;
        while (items_sent < ITEMS_TARGET)
        begin
            burst_mode = ($urandom_range(0, 9) < 2);
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_LEN - 4, MAX_LEN + 2)
                                                : $urandom_range(1, 8);
                for (int k = 0; k < n; k++)
                    send_request(REQ_LOAD, pick_char(), k == 0, 1'($urandom_range(0, 1)),
                                 2'($urandom_range(0, 3)));
            end
            else if (pick < 70)
            begin
                span = int'(ref_len) + $urandom_range(0, 4) - 2;
                qlen = (span < 1) ? 1 : (span > 10 ? 10 : span);
                cp   = 2'($urandom_range(0, 3));
                for (int k = 0; k < qlen; k++)
                begin
                    c = (k < ref_len && $urandom_range(0, 4) != 0) ? ref_chars[k] : pick_char();
                    send_request(REQ_QUERY, c, k == 0, k == qlen - 1,
                                 (k == 0) ? cp : 2'($urandom_range(0, 3)));
                end
            end
            else if (pick < 80)
            begin
                send_request(REQ_EMPTY, CHAR_W'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             2'($urandom_range(0, 3)));
            end
            else
            begin
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                begin
                    kind = 2'($urandom_range(0, 3));
                    f    = 1'($urandom_range(0, 1));
                    // Never continue a query before the row has been set up
                    if (kind == REQ_QUERY && !row_ready)
                        f = 1'b1;
                    send_request(kind, CHAR_W'($urandom_range(0, 255)), f,
                                 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
                end
            end
            if ($urandom_range(0, 19) == 0)
                settle_queries();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        req_type       = REQ_LOAD;
        ch             = '0;
        first          = 1'b0;
        last           = 1'b0;
        cap            = '0;
        ref_len        = 0;
        query_pos      = 0;
        cap_held       = 0;
        row_ready      = 1'b0;
        items_sent     = 0;
        mismatch_count = 0;
        burst_mode     = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_reference();
        test_short_strings();
        test_long_reference();
        test_random_sequences();

        // Drain outstanding scores, then watch for stray strobes
        settle_queries();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_scores.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

[capped_edit_distance_top.f]
+incdir+hw/rtl
hw/rtl/ced_pkg.sv
hw/rtl/ced_ref_store.sv
hw/rtl/ced_row_engine.sv
hw/rtl/capped_edit_distance_top.sv
sim/tb_top.sv
